FILE: hw/rtl/psq_pkg.sv
// Shared types and constants for the power status qualifier.
package psq_pkg;

    localparam int STATUS_W    = 7;
    localparam int CFG_INDEX_W = 4;
    localparam int CFG_DATA_W  = 16;
    localparam int TICKS_W     = 16;
    localparam int IN_TDATA_W  = 8;
    localparam int OUT_TDATA_W = 16;

    // Register indexes of the configuration port
    localparam logic [CFG_INDEX_W-1:0] REG_IS_MK1            = 4'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_FIRST_BOOT        = 4'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_STABLE_TICKS      = 4'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_LIGHTS_HOLD_TICKS = 4'd3;

    localparam logic [TICKS_W-1:0] STABLE_TICKS_RST      = 16'd25;
    localparam logic [TICKS_W-1:0] LIGHTS_HOLD_TICKS_RST = 16'd100;

    // Status word bit positions
    localparam int BIT_BATTERY   = 0;
    localparam int BIT_POWERFAIL = 1;
    localparam int BIT_ACCESSORY = 2;
    localparam int BIT_FIRSTBOOT = 3;
    localparam int BIT_MUTE      = 4;
    localparam int BIT_LIGHTS    = 5;
    localparam int BIT_DISPLAY   = 6;

    typedef struct packed {
        logic               is_mk1;
        logic               first_boot;
        logic [TICKS_W-1:0] stable_ticks;
        logic [TICKS_W-1:0] lights_hold_ticks;
    } cfg_t;

    typedef struct packed {
        logic read_request;
        logic display_on;
        logic on_battery;
        logic cts_level;
        logic dcd_level;
        logic accessory_sense;
        logic powerfail_on;
    } tick_t;

    typedef struct packed {
        logic                pending;
        logic [STATUS_W-1:0] read_data;
        logic [STATUS_W-1:0] status_word;
    } result_t;

endpackage

FILE: hw/rtl/psq_cfg.sv
// Configuration register file for the power status qualifier.
module psq_cfg (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [psq_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [psq_pkg::CFG_DATA_W-1:0]     cfg_data,
    output psq_pkg::cfg_t                      cfg
);

    psq_pkg::cfg_t cfg_reg;
    psq_pkg::cfg_t cfg_next;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid) begin
            unique case (cfg_index)
                psq_pkg::REG_IS_MK1:            cfg_next.is_mk1 = cfg_data[0];
                psq_pkg::REG_FIRST_BOOT:        cfg_next.first_boot = cfg_data[0];
                psq_pkg::REG_STABLE_TICKS:      cfg_next.stable_ticks = cfg_data;
                psq_pkg::REG_LIGHTS_HOLD_TICKS: cfg_next.lights_hold_ticks = cfg_data;
                default: ; // drop writes to unknown registers
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.is_mk1            <= 1'b0;
            cfg_reg.first_boot        <= 1'b0;
            cfg_reg.stable_ticks      <= psq_pkg::STABLE_TICKS_RST;
            cfg_reg.lights_hold_ticks <= psq_pkg::LIGHTS_HOLD_TICKS_RST;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

FILE: hw/rtl/psq_core.sv
// Tick state and status word qualification for the power status qualifier.
module psq_core #(
    parameter int COUNT_WIDTH = 16
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              fire,
    input  psq_pkg::tick_t    tick,
    input  psq_pkg::cfg_t     cfg,
    output psq_pkg::result_t  res
);

    localparam int CMP_W = (COUNT_WIDTH > psq_pkg::TICKS_W) ? COUNT_WIDTH : psq_pkg::TICKS_W;
    localparam logic [COUNT_WIDTH-1:0] CNT_MAX = {COUNT_WIDTH{1'b1}};

    logic [2:0]                   held_reg, held_next;
    logic [COUNT_WIDTH-1:0]       since_match_reg, since_match_next;
    logic [COUNT_WIDTH-1:0]       since_lights_reg, since_lights_next;
    logic [psq_pkg::STATUS_W-1:0] pending_reg, pending_next;
    logic [psq_pkg::STATUS_W-1:0] last_read_reg, last_read_next;

    logic [psq_pkg::STATUS_W-1:0] raw;
    logic [psq_pkg::STATUS_W-1:0] word;
    logic [2:0]                   raw_unst;
    logic [COUNT_WIDTH-1:0]       match_inc, lights_inc;
    logic                         match;
    logic                         lights_stretch;

    always_comb begin
        raw = '0;
        raw[psq_pkg::BIT_BATTERY]   = tick.on_battery;
        raw[psq_pkg::BIT_POWERFAIL] = tick.powerfail_on;
        raw[psq_pkg::BIT_DISPLAY]   = tick.display_on;
        if (cfg.is_mk1) begin
            raw[psq_pkg::BIT_ACCESSORY] = 1'b1;
        end else begin
            raw[psq_pkg::BIT_ACCESSORY] = tick.accessory_sense;
            raw[psq_pkg::BIT_FIRSTBOOT] = cfg.first_boot;
            raw[psq_pkg::BIT_MUTE]      = ~tick.dcd_level;
            raw[psq_pkg::BIT_LIGHTS]    = ~tick.cts_level;
        end

        raw_unst = {raw[psq_pkg::BIT_MUTE], raw[psq_pkg::BIT_ACCESSORY],
                    raw[psq_pkg::BIT_POWERFAIL]};

        match_inc  = (since_match_reg == CNT_MAX) ? CNT_MAX : since_match_reg + 1'b1;
        lights_inc = (since_lights_reg == CNT_MAX) ? CNT_MAX : since_lights_reg + 1'b1;

        // debounce powerfail, accessory and mute
        match            = (held_reg == raw_unst);
        held_next        = held_reg;
        since_match_next = match_inc;
        if (match) begin
            since_match_next = '0;
        end else if (CMP_W'(match_inc) > CMP_W'(cfg.stable_ticks)) begin
            held_next = raw_unst;
        end

        // stretch lights after the last activity
        lights_stretch    = 1'b0;
        since_lights_next = lights_inc;
        if (raw[psq_pkg::BIT_LIGHTS]) begin
            since_lights_next = '0;
        end else if (CMP_W'(lights_inc) < CMP_W'(cfg.lights_hold_ticks)) begin
            lights_stretch = 1'b1;
        end

        word = raw;
        word[psq_pkg::BIT_LIGHTS]    = raw[psq_pkg::BIT_LIGHTS] | lights_stretch;
        word[psq_pkg::BIT_POWERFAIL] = held_next[0];
        word[psq_pkg::BIT_ACCESSORY] = held_next[1];
        word[psq_pkg::BIT_MUTE]      = held_next[2];

        pending_next   = (word != last_read_reg) ? word : pending_reg;
        last_read_next = tick.read_request ? pending_next : last_read_reg;

        res.status_word = pending_next;
        res.read_data   = tick.read_request ? pending_next : '0;
        res.pending     = (pending_next != last_read_next);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            held_reg         <= '0;
            since_match_reg  <= CNT_MAX;
            since_lights_reg <= CNT_MAX;
            pending_reg      <= '0;
            last_read_reg    <= '0;
        end else if (fire) begin
            held_reg         <= held_next;
            since_match_reg  <= since_match_next;
            since_lights_reg <= since_lights_next;
            pending_reg      <= pending_next;
            last_read_reg    <= last_read_next;
        end
    end

    a_read_syncs: assert property (@(posedge aclk) disable iff (!aresetn)
        fire && tick.read_request |=> last_read_reg == pending_reg)
        else $error("read did not sync last read word");

    a_no_read_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        fire && !tick.read_request |-> res.read_data == '0)
        else $error("read data nonzero without read");

    a_match_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        fire && match |=> since_match_reg == '0)
        else $error("match counter not cleared");

    a_idle_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        !fire |=> $stable(pending_reg) && $stable(held_reg) && $stable(last_read_reg))
        else $error("state moved without a tick");

endmodule

FILE: hw/rtl/power_status_qualifier_unit.sv
// Top level of the power status qualifier: input stage, qualifier core, result register.
//
// Each input request is one timer tick carrying the sampled power lines and an
// optional software read; each tick yields exactly one result request holding
// the pending status word, the read data and the pending flag. Status word bits:
// b0 battery, b1 powerfail enabled, b2 accessory, b3 first boot, b4 external mute
// (inverted DCD), b5 lights (inverted CTS), b6 display. Bits 1, 2 and 4 are
// debounced against stable_ticks; the lights bit is held for lights_hold_ticks
// after activity. Throughput is one tick per clock while m_tready keeps the result
// register draining: a tick is held in the input register, is qualified by a single
// pass of combinational logic and lands in the result register, which drives
// m_tvalid. The tick counters are COUNT_WIDTH bits wide and saturate. Write the
// configuration registers (index 0 is_mk1, 1 first_boot, 2 stable_ticks,
// 3 lights_hold_ticks) only while no tick is in flight; unknown indexes are
// dropped and cfg_ready is always high.
module power_status_qualifier_unit #(
    parameter int COUNT_WIDTH = 16
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    // configuration write channel
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [psq_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [psq_pkg::CFG_DATA_W-1:0]      cfg_data,
    // tick input stream
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // [0] powerfail_on, [1] accessory_sense, [2] dcd_level, [3] cts_level,
    // [4] on_battery, [5] display_on, [6] read_request, [7] zero
    input  logic [psq_pkg::IN_TDATA_W-1:0]      s_tdata,
    // result stream
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // [6:0] status_word, [13:7] read_data, [14] pending, [15] zero
    output logic [psq_pkg::OUT_TDATA_W-1:0]     m_tdata
);

    psq_pkg::cfg_t    cfg;
    psq_pkg::tick_t   in_reg;
    logic             in_valid_reg;
    psq_pkg::result_t res;
    psq_pkg::result_t out_reg;
    logic             out_valid_reg;
    logic             fire;

    psq_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // Advance a held tick whenever the result register is free or draining.
    assign fire     = in_valid_reg && (!out_valid_reg || m_tready);
    // Take a new tick whenever the input register empties this cycle.
    assign s_tready = !in_valid_reg || fire;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_reg <= psq_pkg::tick_t'(s_tdata[6:0]);
        end
    end

    psq_core #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .fire    (fire),
        .tick    (in_reg),
        .cfg     (cfg),
        .res     (res)
    );

    // Hold the result until the downstream side takes it.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (fire) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (fire) begin
            out_reg <= res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {1'b0, out_reg};

endmodule
